[design/mctb_pkg.sv]
// mctb_pkg: shared types and codes for the countdown timer bank.
// Holds the slot record layout, opcode/kind/status codes and time scale constants.
// No dependencies.
package mctb_pkg;

    // Operation codes carried on opcode
    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_CREATE = 3'd1,
        OP_CONFIG = 3'd2,
        OP_START  = 3'd3,
        OP_STOP   = 3'd4,
        OP_DELETE = 3'd5,
        OP_STATUS = 3'd6
    } opcode_t;

    // Result kinds
    localparam logic [1:0] KIND_ACK    = 2'd0;
    localparam logic [1:0] KIND_EXPIRY = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    // Slot status codes
    localparam logic [1:0] ST_UNUSED  = 2'd0;
    localparam logic [1:0] ST_RUNNING = 2'd1;
    localparam logic [1:0] ST_STOPPED = 2'd2;
    localparam logic [1:0] ST_DONE    = 2'd3;

    // Timer modes
    localparam logic [1:0] MODE_SINGLE   = 2'd1;
    localparam logic [1:0] MODE_PERIODIC = 2'd2;

    // Timeout units
    localparam logic [1:0] UNIT_MS   = 2'd0;
    localparam logic [1:0] UNIT_SEC  = 2'd1;
    localparam logic [1:0] UNIT_MIN  = 2'd2;
    localparam logic [1:0] UNIT_KEEP = 2'd3;

    // Time scale factors
    localparam int unsigned MS_PER_S  = 1000;
    localparam int unsigned S_PER_MIN = 60;
    localparam logic [15:0] SCALE_SEC = 16'(MS_PER_S);
    localparam logic [15:0] SCALE_MIN = 16'(MS_PER_S * S_PER_MIN);

    // Widths
    localparam int STEP_W  = 10;
    localparam int TIME_W  = 32;
    localparam int PROD_W  = TIME_W + 16;

    // One slot as stored in the slot memory
    typedef struct packed {
        logic [1:0]        status;
        logic [1:0]        mode;
        logic              notify;
        logic [TIME_W-1:0] timeout;
        logic [TIME_W-1:0] count;
    } slot_rec_t;

    // Request into the slot update logic
    typedef struct packed {
        logic              tick;
        opcode_t           op;
        logic [1:0]        mode;
        logic [1:0]        unit;
        logic              notify;
        logic [TIME_W-1:0] tv;
        logic [PROD_W-1:0] prod;
        logic [STEP_W-1:0] step;
    } upd_req_t;

    // Flags back from the slot update logic
    typedef struct packed {
        logic wr;
        logic fire;
    } upd_flags_t;

endpackage

[design/mctb_slot_mem.sv]
// mctb_slot_mem: slot record memory, one write and one read port, registered read.
// Depends on mctb_pkg for the slot record type.
module mctb_slot_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  mctb_pkg::slot_rec_t wr_data,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output mctb_pkg::slot_rec_t rd_data
);
    import mctb_pkg::*;

    slot_rec_t mem [DEPTH];
    slot_rec_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/mctb_slot_update.sv]
// mctb_slot_update: next slot record for one tick visit or one slot command.
// Depends on mctb_pkg for record, request and flag types.
module mctb_slot_update (
    input  mctb_pkg::upd_req_t   req,
    input  mctb_pkg::slot_rec_t  rec_in,
    output mctb_pkg::slot_rec_t  rec_out,
    output mctb_pkg::upd_flags_t flags
);
    import mctb_pkg::*;

    logic [TIME_W-1:0] cnt;
    logic [TIME_W-1:0] scaled;

    // Saturate the scaled timeout to 32 bits
    assign scaled = (|req.prod[PROD_W-1:TIME_W]) ? '1 : req.prod[TIME_W-1:0];

    always_comb
    begin
        rec_out = rec_in;
        flags   = '0;
        cnt     = '0;
        if (req.tick)
        begin
            // Countdown with floor at zero, then expiry handling
            if (rec_in.status == ST_RUNNING)
            begin
                flags.wr = 1'b1;
                if (rec_in.count >= TIME_W'(req.step))
                begin
                    cnt = rec_in.count - TIME_W'(req.step);
                end
                rec_out.count = cnt;
                if (cnt == '0)
                begin
                    case (rec_in.mode)
                        MODE_SINGLE:
                        begin
                            rec_out.status = ST_DONE;
                            flags.fire     = rec_in.notify;
                        end
                        MODE_PERIODIC:
                        begin
                            rec_out.count = rec_in.timeout;
                            flags.fire    = rec_in.notify;
                        end
                        default:
                        begin
                            // unused mode sits at zero, still running
                        end
                    endcase
                end
            end
        end
        else
        begin
            case (req.op)
                OP_CONFIG:
                begin
                    flags.wr       = 1'b1;
                    rec_out.mode   = req.mode;
                    rec_out.notify = req.notify;
                    case (req.unit)
                        UNIT_MS:  rec_out.timeout = req.tv;
                        UNIT_SEC: rec_out.timeout = scaled;
                        UNIT_MIN: rec_out.timeout = scaled;
                        default:  rec_out.timeout = rec_in.timeout;
                    endcase
                end
                OP_START:
                begin
                    flags.wr = 1'b1;
                    if (rec_in.timeout != '0)
                    begin
                        rec_out.status = ST_RUNNING;
                        rec_out.count  = rec_in.timeout;
                    end
                end
                OP_STOP:
                begin
                    flags.wr       = 1'b1;
                    rec_out.status = ST_STOPPED;
                end
                default:
                begin
                    // status read leaves the slot as is
                end
            endcase
        end
    end

endmodule

[design/multi_slot_countdown_timer_bank_unit.sv]
// multi_slot_countdown_timer_bank_unit: bank of countdown timers in fixed slots.
// Depends on mctb_pkg, mctb_slot_mem and mctb_slot_update.
//
//  channel   | handshake               | beat carries
//  ----------+-------------------------+---------------------------------------------
//  command   | start / busy            | opcode, timer_index, timeout_value, mode,
//            |                         | unit, notify
//  result    | result_strobe           | kind, slot, status, last
//  config    | cfg_valid / cfg_ready   | cfg_tick_step
//
// Create, delete and rejected commands are decided in S_IDLE; configure, start, stop and
// status also pass through S_CMD (slot memory read, then update and write back).
// A tick sweeps every slot: it reads one slot per cycle from the slot memory and
// writes it back the next, then gives the final beat in S_TICK_END.
// Results are registered one-cycle strobes, shown in the cycle after they are decided.
// Reset clears allocation, control state and sets tick_step to 1; slot memory
// needs no clearing since create writes a zeroed record. The receiver cannot stall.
module multi_slot_countdown_timer_bank_unit #(
    parameter int NUM_TIMERS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [2:0]                   opcode,
    input  logic [3:0]                   timer_index,
    input  logic [31:0]                  timeout_value,
    input  logic [1:0]                   mode,
    input  logic [1:0]                   unit,
    input  logic                         notify,
    output logic                         result_strobe,
    output logic [1:0]                   kind,
    output logic [3:0]                   slot,
    output logic [1:0]                   status,
    output logic                         last,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [mctb_pkg::STEP_W-1:0]  cfg_tick_step
);
    import mctb_pkg::*;

    localparam int SLOTS = (NUM_TIMERS < 16) ? NUM_TIMERS : 16;
    localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMD,
        S_TICK,
        S_TICK_END
    } state_t;

    // Control state
    state_t            state_reg, state_next;
    logic [SLOTS-1:0]  alloc_reg, alloc_next;
    logic [IW-1:0]     ptr_reg, ptr_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [IW-1:0]     pend_slot_reg, pend_slot_next;
    logic [1:0]        pend_status_reg, pend_status_next;
    logic [STEP_W-1:0] tick_step_reg, tick_step_next;
    logic              strobe_reg, strobe_next;
    logic [1:0]        kind_reg, kind_next;
    logic [3:0]        slot_reg, slot_next;
    logic [1:0]        status_reg, status_next;
    logic              last_reg, last_next;

    // Latched command payload
    opcode_t           op_reg;
    logic [IW-1:0]     cmd_idx_reg;
    logic [TIME_W-1:0] tv_reg;
    logic [1:0]        mode_reg;
    logic [1:0]        unit_reg;
    logic              notify_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic [15:0]       scale_k;

    // Memory ports
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    slot_rec_t         wr_data;
    logic              rd_en;
    logic [IW-1:0]     rd_addr;
    slot_rec_t         rd_data;

    // Update logic
    upd_req_t          upd_req;
    slot_rec_t         upd_rec;
    upd_flags_t        upd_flags;

    logic              accept;
    opcode_t           op_in;
    logic [IW-1:0]     idx_a;
    logic              cmd_ok;
    logic              free_found;
    logic [IW-1:0]     free_idx;
    logic              slot_live;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign op_in     = opcode_t'(opcode);
    assign idx_a     = timer_index[IW-1:0];
    assign cmd_ok    = (32'(timer_index) < SLOTS) && alloc_reg[idx_a];
    assign slot_live = alloc_reg[ptr_reg];

    // Lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!alloc_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    // Timeout scaling product, registered before use
    assign scale_k   = (unit == UNIT_MIN) ? SCALE_MIN : SCALE_SEC;
    assign prod_next = PROD_W'(timeout_value) * PROD_W'(scale_k);

    mctb_slot_mem #(
        .DEPTH (SLOTS),
        .AW    (IW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        upd_req.tick   = (state_reg == S_TICK);
        upd_req.op     = op_reg;
        upd_req.mode   = mode_reg;
        upd_req.unit   = unit_reg;
        upd_req.notify = notify_reg;
        upd_req.tv     = tv_reg;
        upd_req.prod   = prod_reg;
        upd_req.step   = tick_step_reg;
    end

    mctb_slot_update u_upd (
        .req     (upd_req),
        .rec_in  (rd_data),
        .rec_out (upd_rec),
        .flags   (upd_flags)
    );

    // Sequencer next state
    always_comb
    begin
        state_next       = state_reg;
        alloc_next       = alloc_reg;
        ptr_next         = ptr_reg;
        pend_valid_next  = pend_valid_reg;
        pend_slot_next   = pend_slot_reg;
        pend_status_next = pend_status_reg;
        tick_step_next   = tick_step_reg;
        strobe_next      = 1'b0;
        kind_next        = kind_reg;
        slot_next        = slot_reg;
        status_next      = status_reg;
        last_next        = last_reg;
        wr_en            = 1'b0;
        wr_addr          = ptr_reg;
        wr_data          = upd_rec;
        rd_en            = 1'b0;
        rd_addr          = '0;

        if (cfg_valid && cfg_ready)
        begin
            tick_step_next = cfg_tick_step;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op_in)
                        OP_TICK:
                        begin
                            rd_en           = 1'b1;
                            rd_addr         = '0;
                            ptr_next        = '0;
                            pend_valid_next = 1'b0;
                            state_next      = S_TICK;
                        end
                        OP_CREATE:
                        begin
                            strobe_next = 1'b1;
                            status_next = ST_UNUSED;
                            last_next   = 1'b1;
                            if (free_found)
                            begin
                                alloc_next[free_idx] = 1'b1;
                                wr_en     = 1'b1;
                                wr_addr   = free_idx;
                                wr_data   = '0;
                                kind_next = KIND_ACK;
                                slot_next = 4'(free_idx);
                            end
                            else
                            begin
                                kind_next = KIND_ERROR;
                                slot_next = '0;
                            end
                        end
                        OP_DELETE:
                        begin
                            strobe_next = 1'b1;
                            slot_next   = timer_index;
                            status_next = ST_UNUSED;
                            last_next   = 1'b1;
                            if (cmd_ok)
                            begin
                                alloc_next[idx_a] = 1'b0;
                                kind_next         = KIND_ACK;
                            end
                            else
                            begin
                                kind_next = KIND_ERROR;
                            end
                        end
                        OP_CONFIG, OP_START, OP_STOP, OP_STATUS:
                        begin
                            if (cmd_ok)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = idx_a;
                                state_next = S_CMD;
                            end
                            else
                            begin
                                strobe_next = 1'b1;
                                kind_next   = KIND_ERROR;
                                slot_next   = timer_index;
                                status_next = ST_UNUSED;
                                last_next   = 1'b1;
                            end
                        end
                        default:
                        begin
                            strobe_next = 1'b1;
                            kind_next   = KIND_ERROR;
                            slot_next   = timer_index;
                            status_next = ST_UNUSED;
                            last_next   = 1'b1;
                        end
                    endcase
                end
            end

            // Write back the updated slot (not for status) and acknowledge
            S_CMD:
            begin
                wr_en       = upd_flags.wr;
                wr_addr     = cmd_idx_reg;
                strobe_next = 1'b1;
                kind_next   = KIND_ACK;
                slot_next   = 4'(cmd_idx_reg);
                status_next = upd_rec.status;
                last_next   = 1'b1;
                state_next  = S_IDLE;
            end

            // Sweep: slot ptr_reg data is here, next slot is read
            S_TICK:
            begin
                wr_en   = slot_live && upd_flags.wr;
                wr_addr = ptr_reg;
                if (slot_live && upd_flags.fire)
                begin
                    // emit the held event, it is not the final one
                    if (pend_valid_reg)
                    begin
                        strobe_next = 1'b1;
                        kind_next   = KIND_EXPIRY;
                        slot_next   = 4'(pend_slot_reg);
                        status_next = pend_status_reg;
                        last_next   = 1'b0;
                    end
                    pend_valid_next  = 1'b1;
                    pend_slot_next   = ptr_reg;
                    pend_status_next = upd_rec.status;
                end
                if (ptr_reg == IW'(SLOTS - 1))
                begin
                    state_next = S_TICK_END;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = IW'(ptr_reg + 1'b1);
                    ptr_next = IW'(ptr_reg + 1'b1);
                end
            end

            // Final beat of a tick
            S_TICK_END:
            begin
                strobe_next = 1'b1;
                last_next   = 1'b1;
                if (pend_valid_reg)
                begin
                    kind_next   = KIND_EXPIRY;
                    slot_next   = 4'(pend_slot_reg);
                    status_next = pend_status_reg;
                end
                else
                begin
                    kind_next   = KIND_TICK;
                    slot_next   = '0;
                    status_next = ST_UNUSED;
                end
                pend_valid_next = 1'b0;
                state_next      = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            alloc_reg       <= '0;
            ptr_reg         <= '0;
            pend_valid_reg  <= 1'b0;
            pend_slot_reg   <= '0;
            pend_status_reg <= '0;
            tick_step_reg   <= STEP_W'(1);
            strobe_reg      <= 1'b0;
            kind_reg        <= '0;
            slot_reg        <= '0;
            status_reg      <= '0;
            last_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            alloc_reg       <= alloc_next;
            ptr_reg         <= ptr_next;
            pend_valid_reg  <= pend_valid_next;
            pend_slot_reg   <= pend_slot_next;
            pend_status_reg <= pend_status_next;
            tick_step_reg   <= tick_step_next;
            strobe_reg      <= strobe_next;
            kind_reg        <= kind_next;
            slot_reg        <= slot_next;
            status_reg      <= status_next;
            last_reg        <= last_next;
        end
    end

    // Command payload capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= op_in;
            cmd_idx_reg <= idx_a;
            tv_reg      <= timeout_value;
            mode_reg    <= mode;
            unit_reg    <= unit;
            notify_reg  <= notify;
            prod_reg    <= prod_next;
        end
    end

    assign result_strobe = strobe_reg;
    assign kind          = kind_reg;
    assign slot          = slot_reg;
    assign status        = status_reg;
    assign last          = last_reg;

endmodule
